[rtl/drs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delivery rate sampler package
// Shared widths, codes and the types that pass between front and back.
// ----------------------------------------------------------------------------
package drs_pkg;

    localparam int TABLE_DEPTH = 256;   // power of two, slot is the low bits
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int TOT_W   = 48;
    localparam int TIME_W  = 40;
    localparam int PN_W    = 32;
    localparam int SIZE_W  = 16;
    localparam int DVD_W   = 72;        // bytes * 8e6 fits in 71 bits
    localparam int DIV_STEPS = DVD_W / 2;
    localparam int CNT_W   = $clog2(DIV_STEPS);

    localparam logic [DVD_W-1:0] BITS_US = DVD_W'(8000000);
    localparam logic [TOT_W-1:0] RATE_MAX = {TOT_W{1'b1}};

    localparam logic [1:0] OP_SENT  = 2'd0;
    localparam logic [1:0] OP_ACKED = 2'd1;
    localparam logic [1:0] OP_LOST  = 2'd2;
    localparam logic [1:0] OP_UNDEF = 2'd3;

    localparam logic [2:0] ST_SAMPLE    = 3'd0;
    localparam logic [2:0] ST_SEND_LOSS = 3'd1;
    localparam logic [2:0] ST_UNTRACKED = 3'd2;
    localparam logic [2:0] ST_NO_ROUND  = 3'd3;
    localparam logic [2:0] ST_NO_PRIOR  = 3'd4;
    localparam logic [2:0] ST_NOT_LATER = 3'd5;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [TIME_W-1:0] event_time;
        logic [PN_W-1:0]   pkt_num;
        logic [SIZE_W-1:0] packet_bytes;
        logic              flight_empty;
        logic              round_end;
        logic [IDX_W-1:0]  slot;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

    typedef struct packed {
        logic [PN_W-1:0]   number;
        logic [TIME_W-1:0] tx_time;
        logic [SIZE_W-1:0] size;
        logic [TOT_W-1:0]  total_sent;
        logic [TOT_W-1:0]  sent_at_prev_ack;
        logic [TIME_W-1:0] prev_ack_sent_time;
        logic [TIME_W-1:0] prev_ack_time;
        logic [TOT_W-1:0]  acked_at_prev_ack;
    } entry_t;

endpackage

[rtl/drs_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delivery rate sampler front end
// Accepts items, works out the table slot and holds them in a short queue.
// ----------------------------------------------------------------------------
module drs_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    opcode,
    input  logic [drs_pkg::TIME_W-1:0]    event_time,
    input  logic [drs_pkg::PN_W-1:0]      pkt_num,
    input  logic [drs_pkg::SIZE_W-1:0]    packet_bytes,
    input  logic                          flight_empty,
    input  logic                          round_end,
    output drs_pkg::queue_head_t          head,
    input  logic                          pop
);

    drs_pkg::item_t              queue_mem [drs_pkg::QUEUE_DEPTH];
    logic [drs_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [drs_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [drs_pkg::QPTR_W:0]    count_reg;
    logic                        push;
    logic                        do_pop;
    drs_pkg::item_t              new_item;

    assign in_stall = (count_reg == (drs_pkg::QPTR_W+1)'(drs_pkg::QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign do_pop   = pop && (count_reg != '0);

    always_comb
    begin
        new_item.opcode        = opcode;
        new_item.event_time    = event_time;
        new_item.pkt_num       = pkt_num;
        new_item.packet_bytes  = packet_bytes;
        new_item.flight_empty  = flight_empty;
        new_item.round_end     = round_end;
        new_item.slot          = pkt_num[drs_pkg::IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = queue_mem[rd_ptr_reg];

endmodule

[rtl/drs_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delivery rate sampler divider
// Restoring divider, two quotient bits a cycle, result saturated to 48 bits.
// ----------------------------------------------------------------------------
module drs_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [drs_pkg::DVD_W-1:0]     dividend,
    input  logic [drs_pkg::TIME_W-1:0]    divisor,
    output logic                          busy,
    output logic [drs_pkg::TOT_W-1:0]     rate
);

    logic                          busy_reg;
    logic [drs_pkg::CNT_W-1:0]     cnt_reg;
    logic [drs_pkg::TIME_W-1:0]    rem_reg;
    logic [drs_pkg::TIME_W-1:0]    rem_next;
    logic [drs_pkg::DVD_W-1:0]     dq_reg;
    logic [drs_pkg::DVD_W-1:0]     dq_next;
    logic [drs_pkg::TIME_W-1:0]    dvs_reg;
    logic [drs_pkg::TIME_W:0]      trial1;
    logic [drs_pkg::TIME_W:0]      trial2;
    logic [drs_pkg::TIME_W-1:0]    rem1;
    logic                          bit1;
    logic                          bit2;

    // Two dependent subtract steps; quotient bits shift in at the bottom.
    always_comb
    begin
        trial1 = {rem_reg, dq_reg[drs_pkg::DVD_W-1]};
        bit1   = (trial1 >= {1'b0, dvs_reg});
        if (bit1)
        begin
            trial1 = trial1 - {1'b0, dvs_reg};
        end
        rem1   = trial1[drs_pkg::TIME_W-1:0];
        trial2 = {rem1, dq_reg[drs_pkg::DVD_W-2]};
        bit2   = (trial2 >= {1'b0, dvs_reg});
        if (bit2)
        begin
            trial2 = trial2 - {1'b0, dvs_reg};
        end
        rem_next = trial2[drs_pkg::TIME_W-1:0];
        dq_next  = {dq_reg[drs_pkg::DVD_W-3:0], bit1, bit2};
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dq_reg  <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == drs_pkg::CNT_W'(drs_pkg::DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;
    assign rate = (dq_reg[drs_pkg::DVD_W-1:drs_pkg::TOT_W] != '0) ? drs_pkg::RATE_MAX
                                                                 : dq_reg[drs_pkg::TOT_W-1:0];

endmodule

[rtl/drs_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delivery rate sampler back end
// Owns the packet table and totals, runs one item at a time to a result.
// ----------------------------------------------------------------------------
module drs_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  drs_pkg::queue_head_t          head,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [drs_pkg::TOT_W-1:0]     bandwidth_bps,
    output logic [2:0]                    status
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]                    state_reg;
    logic [2:0]                    state_next;
    drs_pkg::item_t                cur_reg;
    drs_pkg::entry_t               table_mem [drs_pkg::TABLE_DEPTH];
    drs_pkg::entry_t               rd_reg;
    drs_pkg::entry_t               wr_data;
    logic                          wr_en;
    logic [drs_pkg::TABLE_DEPTH-1:0] valid_reg;

    logic [drs_pkg::TOT_W-1:0]     total_sent_reg;
    logic [drs_pkg::TOT_W-1:0]     total_acked_reg;
    logic [drs_pkg::TOT_W-1:0]     sent_at_prev_ack_reg;
    logic [drs_pkg::TIME_W-1:0]    prev_ack_sent_time_reg;
    logic [drs_pkg::TIME_W-1:0]    prev_ack_time_reg;

    logic [drs_pkg::TOT_W-1:0]     ts_new;
    logic [drs_pkg::TOT_W-1:0]     sapa_new;
    logic [drs_pkg::TIME_W-1:0]    pas_new;
    logic [drs_pkg::TIME_W-1:0]    pat_new;
    logic [drs_pkg::TOT_W-1:0]     ta_new;
    logic                          hit;
    logic [2:0]                    ack_status;
    logic [2:0]                    exec_status;

    logic [drs_pkg::TOT_W-1:0]     ack_bytes_reg;
    logic [drs_pkg::TIME_W-1:0]    ack_delta_reg;
    logic [drs_pkg::TOT_W-1:0]     send_bytes_reg;
    logic [drs_pkg::TIME_W-1:0]    send_delta_reg;
    logic                          send_en_reg;
    logic [drs_pkg::TOT_W-1:0]     res_bw_reg;
    logic [2:0]                    res_status_reg;

    logic                          out_valid_reg;
    logic [drs_pkg::TOT_W-1:0]     out_bw_reg;
    logic [2:0]                    out_status_reg;

    logic                          div_start;
    logic                          ack_busy;
    logic                          send_busy;
    logic [drs_pkg::TOT_W-1:0]     ack_bw;
    logic [drs_pkg::TOT_W-1:0]     tx_bw;
    logic                          out_free;

    assign pop       = (state_reg == S_IDLE) && head.valid;
    assign div_start = (state_reg == S_MUL);
    assign out_free  = !out_valid_reg || !out_stall;

    drs_div u_ack_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({{(drs_pkg::DVD_W-drs_pkg::TOT_W){1'b0}}, ack_bytes_reg}
                   * drs_pkg::BITS_US),
        .divisor  (ack_delta_reg),
        .busy     (ack_busy),
        .rate     (ack_bw)
    );

    drs_div u_send_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({{(drs_pkg::DVD_W-drs_pkg::TOT_W){1'b0}}, send_bytes_reg}
                   * drs_pkg::BITS_US),
        .divisor  (send_delta_reg),
        .busy     (send_busy),
        .rate     (tx_bw)
    );

    always_comb
    begin
        ts_new   = total_sent_reg + drs_pkg::TOT_W'(cur_reg.packet_bytes);
        sapa_new = cur_reg.flight_empty ? ts_new : sent_at_prev_ack_reg;
        pas_new  = cur_reg.flight_empty ? cur_reg.event_time : prev_ack_sent_time_reg;
        pat_new  = cur_reg.flight_empty ? cur_reg.event_time : prev_ack_time_reg;
        ta_new   = total_acked_reg + drs_pkg::TOT_W'(rd_reg.size);
        hit      = valid_reg[cur_reg.slot] && (rd_reg.number == cur_reg.pkt_num);

        if (!cur_reg.round_end)
        begin
            ack_status = drs_pkg::ST_NO_ROUND;
        end
        else if (rd_reg.prev_ack_sent_time == '0)
        begin
            ack_status = drs_pkg::ST_NO_PRIOR;
        end
        else if (cur_reg.event_time <= rd_reg.prev_ack_time)
        begin
            ack_status = drs_pkg::ST_NOT_LATER;
        end
        else
        begin
            ack_status = drs_pkg::ST_SAMPLE;
        end

        // Sends, losses and undefined codes all report the send-or-loss code.
        exec_status = drs_pkg::ST_SEND_LOSS;
        if (cur_reg.opcode == drs_pkg::OP_ACKED)
        begin
            exec_status = hit ? ack_status : drs_pkg::ST_UNTRACKED;
        end

        wr_en                      = (state_reg == S_EXEC) && (cur_reg.opcode == drs_pkg::OP_SENT);
        wr_data.number             = cur_reg.pkt_num;
        wr_data.tx_time            = cur_reg.event_time;
        wr_data.size               = cur_reg.packet_bytes;
        wr_data.total_sent         = ts_new;
        wr_data.sent_at_prev_ack   = sapa_new;
        wr_data.prev_ack_sent_time = pas_new;
        wr_data.prev_ack_time      = pat_new;
        wr_data.acked_at_prev_ack  = total_acked_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rd_reg <= table_mem[head.item.slot];
        end
        if (wr_en)
        begin
            table_mem[cur_reg.slot] <= wr_data;
        end
    end

    // Item payload, divider operands and the output register payload.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head.item;
        end
        if (state_reg == S_EXEC)
        begin
            ack_bytes_reg  <= ta_new - rd_reg.acked_at_prev_ack;
            ack_delta_reg  <= cur_reg.event_time - rd_reg.prev_ack_time;
            send_bytes_reg <= rd_reg.total_sent - rd_reg.sent_at_prev_ack;
            send_delta_reg <= rd_reg.tx_time - rd_reg.prev_ack_sent_time;
            send_en_reg    <= rd_reg.tx_time > rd_reg.prev_ack_sent_time;
        end
        if ((state_reg == S_OUT) && out_free)
        begin
            out_bw_reg     <= res_bw_reg;
            out_status_reg <= res_status_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if ((cur_reg.opcode == drs_pkg::OP_ACKED) && hit
                    && (ack_status == drs_pkg::ST_SAMPLE))
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (!ack_busy && !send_busy)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg              <= S_IDLE;
            valid_reg              <= '0;
            total_sent_reg         <= '0;
            total_acked_reg        <= '0;
            sent_at_prev_ack_reg   <= '0;
            prev_ack_sent_time_reg <= '0;
            prev_ack_time_reg      <= '0;
            res_bw_reg             <= '0;
            res_status_reg         <= drs_pkg::ST_SEND_LOSS;
            out_valid_reg          <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_EXEC)
            begin
                res_bw_reg     <= '0;
                res_status_reg <= exec_status;
                case (cur_reg.opcode)
                    drs_pkg::OP_SENT:
                    begin
                        total_sent_reg           <= ts_new;
                        sent_at_prev_ack_reg     <= sapa_new;
                        prev_ack_sent_time_reg   <= pas_new;
                        prev_ack_time_reg        <= pat_new;
                        valid_reg[cur_reg.slot]  <= 1'b1;
                    end
                    drs_pkg::OP_ACKED:
                    begin
                        if (hit)
                        begin
                            total_acked_reg         <= ta_new;
                            sent_at_prev_ack_reg    <= rd_reg.total_sent;
                            prev_ack_sent_time_reg  <= rd_reg.tx_time;
                            prev_ack_time_reg       <= cur_reg.event_time;
                            valid_reg[cur_reg.slot] <= 1'b0;
                        end
                    end
                    drs_pkg::OP_LOST:
                    begin
                        if (hit)
                        begin
                            valid_reg[cur_reg.slot] <= 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if ((state_reg == S_DIV) && !ack_busy && !send_busy)
            begin
                res_bw_reg <= (send_en_reg && (tx_bw < ack_bw)) ? tx_bw : ack_bw;
            end
            if ((state_reg == S_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign bandwidth_bps = out_bw_reg;
    assign status        = out_status_reg;

    a_zero_without_sample: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_status_reg == drs_pkg::ST_SAMPLE) || (out_bw_reg == '0))
        else $error("bandwidth non-zero on a result that is not a sample");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == S_IDLE))
        else $error("queue popped while an item is in progress");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_status_reg <= drs_pkg::ST_NOT_LATER))
        else $error("status code out of range");

    a_div_follows_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |=> ack_busy && send_busy)
        else $error("dividers not running after start");

endmodule

[rtl/delivery_rate_sampler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delivery rate sampler
// Per-packet bandwidth sampler: records send snapshots, samples on ack.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake             Payload
//  input     in_valid / in_stall   opcode, event_time, pkt_num,
//                                  packet_bytes, flight_empty, round_end
//  output    out_valid / out_stall bandwidth_bps, status
//
// A send, a loss or an ack that gives no sample passes the back end through
// pop, execute and hand-off to the output register. An ack that gives a
// sample also starts the two rate dividers, which run side by side at two
// quotient bits a cycle over a 72-bit dividend, and waits for both to end.
// An accepted item waits in the queue until the back end is idle and pops it.
// Reset clears the totals and the slot valid bits at once; the table needs
// no clearing pass. A two-item queue lets the input side keep accepting
// while the back end works or waits on a stalled output register.
//
module delivery_rate_sampler
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    opcode,
    input  logic [drs_pkg::TIME_W-1:0]    event_time,
    input  logic [drs_pkg::PN_W-1:0]      pkt_num,
    input  logic [drs_pkg::SIZE_W-1:0]    packet_bytes,
    input  logic                          flight_empty,
    input  logic                          round_end,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [drs_pkg::TOT_W-1:0]     bandwidth_bps,
    output logic [2:0]                    status
);

    // The queue head travels as one bundle; the back end pops it when idle.
    drs_pkg::queue_head_t head;
    logic                 pop;

    drs_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .event_time    (event_time),
        .pkt_num       (pkt_num),
        .packet_bytes  (packet_bytes),
        .flight_empty  (flight_empty),
        .round_end     (round_end),
        .head          (head),
        .pop           (pop)
    );

    // The back end owns the table, the totals and the output register.
    drs_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .bandwidth_bps (bandwidth_bps),
        .status        (status)
    );

endmodule
